// ===== hw/rtl/radix_integer_to_text_macros.svh =====
// Assertion macros for the radix integer-to-text converter.
// Used by radix_integer_to_text.sv; expects clk and rst_n in scope.
`ifndef RADIX_INTEGER_TO_TEXT_MACROS_SVH
`define RADIX_INTEGER_TO_TEXT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rit_pkg.sv =====
// Shared constants, state codes and the digit character lookup for the
// radix integer-to-text converter. No dependencies.
package rit_pkg;

    localparam int VALUE_W   = 64;
    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 7;
    localparam int BASE_W    = 5;
    localparam int DIGIT_W   = 4;
    localparam int ADDR_W    = 6;
    localparam int MAX_DIGITS = 64;
    localparam int BITS_PER_STEP = 8;
    localparam int STEP_W    = 3;
    localparam int TDATA_O_W = 16;

    localparam logic [BASE_W-1:0] MAX_BASE  = 5'd16;
    localparam logic [BASE_W-1:0] MIN_BASE  = 5'd2;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    // Configuration register indexes.
    localparam logic [1:0] REG_BASE        = 2'd0;
    localparam logic [1:0] REG_DIGITS_LOW  = 2'd1;
    localparam logic [1:0] REG_DIGITS_HIGH = 2'd2;

    localparam logic [BASE_W-1:0]  BASE_RESET      = 5'd10;
    localparam logic [63:0]        DIGITS_LO_RESET = 64'h3736353433323130;
    localparam logic [63:0]        DIGITS_HI_RESET = 64'h6665646362613938;

    // Request kinds.
    localparam logic [1:0] TYPE_U32 = 2'd0;
    localparam logic [1:0] TYPE_U64 = 2'd1;
    localparam logic [1:0] TYPE_S32 = 2'd2;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    typedef logic [DIGIT_W-1:0] digit_t;

    function automatic logic [CHAR_W-1:0] digit_char(
        input digit_t      d,
        input logic [63:0] lo,
        input logic [63:0] hi
    );
        logic [63:0] word;
        begin
            word = d[3] ? hi : lo;
            digit_char = word[{d[2:0], 3'b000} +: CHAR_W];
        end
    endfunction

endpackage

// ===== hw/rtl/radix_integer_to_text.sv =====
// Radix integer-to-text converter: top level with the divide sequencer,
// digit store and output register. Depends on rit_pkg and the macros header.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tdata = value, s_tuser = req_type
//  m_*      out  m_tvalid / m_tready    m_tdata = out_char, char_count; m_tlast
//  cfg_*    in   cfg_we                 cfg_addr = register index, cfg_data
//
// Each digit is formed in ST_DIV by the shared 8-bit-per-cycle divide step and then
// written in ST_STORE; after dividing come the minus sign if any (ST_SIGN), a read step
// (ST_RD), and one character per cycle while m_tready allows (ST_EMIT). A new request
// is accepted only in ST_IDLE, once the last character of the previous one is loaded.
// Reset returns the configuration to base 10 and digits "0123456789abcdef".
// A low m_tready holds the character in the output register and pauses output.
`include "radix_integer_to_text_macros.svh"

module radix_integer_to_text (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rit_pkg::VALUE_W-1:0]       s_tdata,   // [63:0] value
    input  logic [1:0]                        s_tuser,   // [1:0] req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rit_pkg::TDATA_O_W-1:0]     m_tdata,   // [7:0] out_char, [14:8] char_count
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_addr,
    input  logic [63:0]                       cfg_data
);
    import rit_pkg::*;

    logic [BASE_W-1:0]   base_len_reg;
    logic [63:0]         dig_lo_reg;
    logic [63:0]         dig_hi_reg;

    logic [2:0]          state_reg, state_next;
    logic [VALUE_W-1:0]  wk_reg, wk_next;
    digit_t              rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic                neg_reg, neg_next;
    logic [COUNT_W-1:0]  nd_reg, nd_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;

    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [COUNT_W-1:0]  ocnt_reg, ocnt_next;
    logic                olast_reg, olast_next;

    digit_t              mem [MAX_DIGITS];
    digit_t              mem_q_reg;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;

    logic                accept;
    logic                slot_free;
    logic                load;
    logic [BASE_W-1:0]   eff_base;
    logic [31:0]         low_word;

    logic [BASE_W-1:0]   div_r;
    logic [VALUE_W-1:0]  div_w;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign load      = slot_free && ((state_reg == ST_SIGN) || (state_reg == ST_EMIT));
    assign low_word  = s_tdata[31:0];
    assign wr_en     = (state_reg == ST_STORE);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_O_W - CHAR_W - COUNT_W){1'b0}}, ocnt_reg, char_reg};
    assign m_tlast  = olast_reg;

    // Clamp the configured base into the legal range.
    always_comb
    begin
        if (base_len_reg < MIN_BASE)
            eff_base = MIN_BASE;
        else if (base_len_reg > MAX_BASE)
            eff_base = MAX_BASE;
        else
            eff_base = base_len_reg;
    end

    // Shared divide unit: eight restoring steps of long division by the base.
    always_comb
    begin
        div_r = {1'b0, rem_reg};
        div_w = wk_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            div_r = {div_r[DIGIT_W-1:0], div_w[VALUE_W-1]};
            div_w = {div_w[VALUE_W-2:0], 1'b0};
            if (div_r >= base_reg)
            begin
                div_r    = div_r - base_reg;
                div_w[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        wk_next      = wk_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        base_next    = base_reg;
        neg_next     = neg_reg;
        nd_next      = nd_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        ocnt_next    = ocnt_reg;
        olast_next   = olast_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    base_next = eff_base;
                    rem_next  = '0;
                    step_next = '0;
                    nd_next   = '0;
                    cnt_next  = '0;
                    neg_next  = 1'b0;
                    case (s_tuser)
                        TYPE_U64: wk_next = s_tdata;
                        TYPE_S32:
                        begin
                            if (low_word[31])
                            begin
                                neg_next = 1'b1;
                                wk_next  = {32'd0, ~low_word + 32'd1};
                            end
                            else
                                wk_next = {32'd0, low_word};
                        end
                        default: wk_next = {32'd0, low_word};
                    endcase
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                wk_next   = div_w;
                rem_next  = div_r[DIGIT_W-1:0];
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_W'(BITS_PER_STEP - 1))
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                // The remainder just finished is written to the digit store here.
                nd_next  = nd_reg + 7'd1;
                idx_next = nd_reg[ADDR_W-1:0];
                if (wk_reg == '0)
                    state_next = neg_reg ? ST_SIGN : ST_RD;
                else
                begin
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_SIGN:
            begin
                if (load)
                begin
                    m_valid_next = 1'b1;
                    char_next    = MINUS_CHAR;
                    ocnt_next    = 7'd1;
                    olast_next   = 1'b0;
                    cnt_next     = 7'd1;
                    state_next   = ST_RD;
                end
            end
            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    m_valid_next = 1'b1;
                    char_next    = digit_char(mem_q_reg, dig_lo_reg, dig_hi_reg);
                    ocnt_next    = cnt_reg + 7'd1;
                    cnt_next     = cnt_reg + 7'd1;
                    olast_next   = (idx_reg == '0);
                    if (idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        // Fetch the next lower digit while this one goes out.
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - 6'd1;
                        idx_next = idx_reg - 6'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg <= BASE_RESET;
            dig_lo_reg   <= DIGITS_LO_RESET;
            dig_hi_reg   <= DIGITS_HI_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BASE:        base_len_reg <= cfg_data[BASE_W-1:0];
                REG_DIGITS_LOW:  dig_lo_reg   <= cfg_data;
                REG_DIGITS_HIGH: dig_hi_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
            nd_reg      <= '0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
            nd_reg      <= nd_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            neg_reg     <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wk_reg    <= wk_next;
        rem_reg   <= rem_next;
        base_reg  <= base_next;
        char_reg  <= char_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    // Digit store: written least significant digit first, read back in reverse.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[nd_reg[ADDR_W-1:0]] <= rem_reg;
        if (rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    `RIT_ASSERT_NOW(a_rem_below_base, (state_reg == ST_DIV), ({1'b0, rem_reg} < base_reg), "remainder not below base")
    `RIT_ASSERT_NOW(a_count_range, m_valid_reg, ((ocnt_reg != 7'd0) && (ocnt_reg <= 7'd64)), "character count out of range")
    `RIT_ASSERT_NEXT(a_last_ends_item, (load && olast_next), (state_reg == ST_IDLE), "last character did not end the item")

endmodule
